// ===== rtl/four_level_page_table_mapper_assert.svh =====
// -----------------------------------------------------------------------------
// Four-level page table mapper: assertion macros
// Shared macros for the concurrent checks of the mapper.
// -----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FPTM_ASSERT_SAME(lbl_, clk_, rst_n_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |-> (cons_)) \
    else $error(msg_);

// Next-cycle implication, disabled while reset is low.
`define FPTM_ASSERT_NEXT(lbl_, clk_, rst_n_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |=> (cons_)) \
    else $error(msg_);

`endif

// ===== rtl/fptm_pkg.sv =====
// -----------------------------------------------------------------------------
// Four-level page table mapper package
// Widths, flag bits, codes and shared types of the mapper.
// -----------------------------------------------------------------------------
package fptm_pkg;

  localparam int POOL_PAGES_DEF = 16;

  localparam int ENTRY_W = 64;
  localparam int PA_W    = 52;
  localparam int VA_W    = 48;
  localparam int PG_W    = 40;
  localparam int VPG_W   = 36;
  localparam int IDX_W   = 9;
  localparam int FLAGS_W = 64;
  localparam int OPT_W   = 3;
  localparam int RTAB_W  = 4;
  localparam int USED_W  = 5;

  localparam logic [ENTRY_W-1:0] PG_PRESENT = ENTRY_W'(1) << 0;
  localparam logic [ENTRY_W-1:0] PG_RW      = ENTRY_W'(1) << 1;
  localparam logic [FLAGS_W-1:0] ELF_W_BIT  = FLAGS_W'(1) << 1;
  localparam logic [FLAGS_W-1:0] ELF_R_BIT  = FLAGS_W'(1) << 2;

  localparam int OPT_ELF   = 0;
  localparam int OPT_X86   = 1;
  localparam int OPT_ALLOC = 2;

  typedef enum logic {
    OP_MAP  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_FLAG = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic {
    AU_ADD = 1'b0,
    AU_SUB = 1'b1
  } au_op_t;

  typedef struct packed {
    logic               tag;
    logic [ENTRY_W-1:0] data;
  } mem_word_t;

endpackage

// ===== rtl/fptm_if.sv =====
// -----------------------------------------------------------------------------
// Four-level page table mapper channels
// Valid/ready channels for map and read requests and for their results.
// -----------------------------------------------------------------------------
interface fptm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [47:0] vaddr;
  logic [51:0] paddr;
  logic [63:0] flags;
  logic [2:0]  option;
  logic [3:0]  read_table;
  logic [8:0]  read_entry;

  modport source (
    output valid, operation, vaddr, paddr, flags, option, read_table, read_entry,
    input  ready
  );
  modport sink (
    input  valid, operation, vaddr, paddr, flags, option, read_table, read_entry,
    output ready
  );
endinterface

interface fptm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] entry_value;
  logic [51:0] mapped_phys;
  logic [4:0]  pages_used;

  modport source (
    output valid, status, entry_value, mapped_phys, pages_used,
    input  ready
  );
  modport sink (
    input  valid, status, entry_value, mapped_phys, pages_used,
    output ready
  );
endinterface

// ===== rtl/fptm_mem.sv =====
// -----------------------------------------------------------------------------
// Four-level page table mapper: table store
// Single write port, single read port memory with registered read data.
// -----------------------------------------------------------------------------
module fptm_mem import fptm_pkg::*; #(
  parameter int DEPTH = POOL_PAGES_DEF * 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  mem_word_t       wr_data,
  input  logic [AW-1:0]   rd_addr,
  output mem_word_t       rd_data
);

  mem_word_t mem [DEPTH];
  mem_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fptm_addr_unit.sv =====
// -----------------------------------------------------------------------------
// Four-level page table mapper: page address unit
// Shared adder that turns pool page indices into page frames and back.
// -----------------------------------------------------------------------------
module fptm_addr_unit import fptm_pkg::*; #(
  parameter int POOL_PAGES = POOL_PAGES_DEF
) (
  input  au_op_t          op,
  input  logic [PG_W-1:0] base_pg,
  input  logic [PG_W-1:0] operand,
  output logic [PG_W-1:0] result,
  output logic            in_pool
);

  always_comb begin
    if (op == AU_ADD) begin
      result = base_pg + operand;
    end else begin
      result = operand - base_pg;
    end
    in_pool = (result < PG_W'(POOL_PAGES));
  end

endmodule

// ===== rtl/four_level_page_table_mapper.sv =====
// -----------------------------------------------------------------------------
// Four-level page table mapper
// Builds x86-64 PML4/PDPT/PD/PT tables in an internal pool of table pages.
// -----------------------------------------------------------------------------
// After reset the block sweeps all POOL_PAGES*512 entries of its table
// store, one entry per cycle, before it takes its first transfer;
// configuration writes are taken throughout. A read addresses the store in
// S_RREAD and takes the entry in S_RDATA. A map walks up to three table
// levels through the single registered memory read port to check the walk,
// then reads the levels again to link missing tables, followed by the
// leaf write. Flags that translate to zero are answered without a table
// walk. One item is processed at a time, and a new transfer is taken while
// the previous result still waits in the output register.
// -----------------------------------------------------------------------------
module four_level_page_table_mapper import fptm_pkg::*; #(
  parameter int POOL_PAGES = POOL_PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [PA_W-1:0]   cfg_wr_data,
  fptm_in_if.sink           in_if,
  fptm_out_if.source        out_if
);

  `include "four_level_page_table_mapper_assert.svh"

  localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int DEPTH = POOL_PAGES * 512;
  localparam int AW    = PW + IDX_W;
  localparam int CW    = $clog2(POOL_PAGES + 1);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_RREAD  = 12'b000000000100,
    S_RDATA  = 12'b000000001000,
    S_WREAD  = 12'b000000010000,
    S_WCHK   = 12'b000000100000,
    S_CHECK  = 12'b000001000000,
    S_PHYS   = 12'b000010000000,
    S_CREAD  = 12'b000100000000,
    S_CWRITE = 12'b001000000000,
    S_LEAF   = 12'b010000000000,
    S_FINISH = 12'b100000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [1:0]          lvl_r, lvl_nxt;
  logic [PW-1:0]       cur_r, cur_nxt;
  logic [2:0]          missing_r, missing_nxt;
  logic                foreign_r, foreign_nxt;
  logic                alloc_r, alloc_nxt;
  logic [VPG_W-1:0]    virt_pg_r, virt_pg_nxt;
  logic [PG_W-1:0]     phys_pg_r, phys_pg_nxt;
  logic [FLAGS_W-1:0]  fx_r, fx_nxt;
  logic [IDX_W-1:0]    rent_r, rent_nxt;
  logic [PG_W-1:0]     paddr_pg_r, paddr_pg_nxt;
  logic [CW-1:0]       next_free_r, next_free_nxt;
  logic [PA_W-1:0]     pool_base_r, pool_base_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [ENTRY_W-1:0]  res_value_r, res_value_nxt;
  logic [PA_W-1:0]     res_mphys_r, res_mphys_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ENTRY_W-1:0]  out_value_r, out_value_nxt;
  logic [PA_W-1:0]     out_mphys_r, out_mphys_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;

  logic                in_xfer;
  logic [FLAGS_W-1:0]  in_fx;
  logic [IDX_W-1:0]    lvl_idx;
  logic                cur_tag;
  mem_word_t           rd_word;
  logic [ENTRY_W-1:0]  entry_rd;
  logic                present;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  mem_word_t           wr_data;
  au_op_t              au_op;
  logic [PG_W-1:0]     au_operand;
  logic [PG_W-1:0]     au_result;
  logic                au_in_pool;
  logic [3:0]          need;
  logic [ENTRY_W-1:0]  leaf_value;

  // A page holds live entries from its allocation on; entries written under
  // another allocation state read back as zero.
  function automatic logic tag_of(input logic [PW-1:0] page, input logic [CW-1:0] nfree);
    return (page != '0) && (CW'(page) < nfree);
  endfunction

  assign in_xfer = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    if (in_if.option[OPT_ELF]) begin
      in_fx = ((in_if.flags & (ELF_W_BIT | ELF_R_BIT)) != '0) ? PG_RW : '0;
    end else if (in_if.option[OPT_X86]) begin
      in_fx = in_if.flags;
    end else begin
      in_fx = '0;
    end
  end

  always_comb begin
    case (lvl_r)
      2'd0:    lvl_idx = virt_pg_r[35:27];
      2'd1:    lvl_idx = virt_pg_r[26:18];
      default: lvl_idx = virt_pg_r[17:9];
    endcase
  end

  assign cur_tag  = tag_of(cur_r, next_free_r);
  assign entry_rd = (rd_word.tag == cur_tag) ? rd_word.data : '0;
  assign present  = entry_rd[0];
  assign rd_addr  = {cur_r, (state_r == S_RREAD) ? rent_r : lvl_idx};
  assign need     = {1'b0, missing_r} + {3'b000, alloc_r};
  assign leaf_value = {12'b0, paddr_pg_r, 12'b0} | fx_r | PG_PRESENT;

  always_comb begin
    if ((state_r == S_PHYS) || ((state_r == S_CWRITE) && !present)) begin
      au_op      = AU_ADD;
      au_operand = PG_W'(next_free_r);
    end else begin
      au_op      = AU_SUB;
      au_operand = entry_rd[PA_W-1:12];
    end
  end

  fptm_addr_unit #(
    .POOL_PAGES (POOL_PAGES)
  ) u_addr_unit (
    .op      (au_op),
    .base_pg (pool_base_r[PA_W-1:12]),
    .operand (au_operand),
    .result  (au_result),
    .in_pool (au_in_pool)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_CWRITE: begin
        wr_en        = !present;
        wr_addr      = {cur_r, lvl_idx};
        wr_data.tag  = tag_of(cur_r, next_free_nxt);
        wr_data.data = {12'b0, au_result, 12'b0} | PG_PRESENT | PG_RW;
      end
      S_LEAF: begin
        wr_en        = 1'b1;
        wr_addr      = {cur_r, virt_pg_r[8:0]};
        wr_data.tag  = cur_tag;
        wr_data.data = leaf_value;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  fptm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    lvl_nxt        = lvl_r;
    cur_nxt        = cur_r;
    missing_nxt    = missing_r;
    foreign_nxt    = foreign_r;
    alloc_nxt      = alloc_r;
    virt_pg_nxt    = virt_pg_r;
    phys_pg_nxt    = phys_pg_r;
    fx_nxt         = fx_r;
    rent_nxt       = rent_r;
    paddr_pg_nxt   = paddr_pg_r;
    next_free_nxt  = next_free_r;
    pool_base_nxt  = cfg_wr_en ? cfg_wr_data : pool_base_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_mphys_nxt  = res_mphys_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_mphys_nxt  = out_mphys_r;
    out_used_nxt   = out_used_r;

    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          virt_pg_nxt    = in_if.vaddr[VA_W-1:12];
          phys_pg_nxt    = in_if.paddr[PA_W-1:12];
          fx_nxt         = in_fx;
          alloc_nxt      = in_if.option[OPT_ALLOC];
          rent_nxt       = in_if.read_entry;
          lvl_nxt        = 2'd0;
          cur_nxt        = '0;
          foreign_nxt    = 1'b0;
          missing_nxt    = 3'd0;
          res_status_nxt = STATUS_OK;
          res_value_nxt  = '0;
          res_mphys_nxt  = '0;
          if (op_t'(in_if.operation) == OP_READ) begin
            if (32'(in_if.read_table) < POOL_PAGES) begin
              cur_nxt   = PW'(in_if.read_table);
              state_nxt = S_RREAD;
            end else begin
              state_nxt = S_FINISH;
            end
          end else if (in_fx == '0) begin
            res_status_nxt = STATUS_ZERO_FLAG;
            state_nxt      = S_FINISH;
          end else begin
            state_nxt = S_WREAD;
          end
        end
      end
      S_RREAD: begin
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        res_value_nxt = entry_rd;
        state_nxt     = S_FINISH;
      end
      S_WREAD: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (!present) begin
          missing_nxt = 3'd3 - {1'b0, lvl_r};
          state_nxt   = S_CHECK;
        end else if (!au_in_pool) begin
          foreign_nxt = 1'b1;
          state_nxt   = S_CHECK;
        end else begin
          cur_nxt = au_result[PW-1:0];
          if (lvl_r == 2'd2) begin
            state_nxt = S_CHECK;
          end else begin
            lvl_nxt   = lvl_r + 2'd1;
            state_nxt = S_WREAD;
          end
        end
      end
      S_CHECK: begin
        lvl_nxt      = 2'd0;
        cur_nxt      = '0;
        paddr_pg_nxt = phys_pg_r;
        if (foreign_r || ((32'(next_free_r) + 32'(need)) > POOL_PAGES)) begin
          res_status_nxt = STATUS_EXHAUSTED;
          state_nxt      = S_FINISH;
        end else if (alloc_r) begin
          state_nxt = S_PHYS;
        end else begin
          state_nxt = S_CREAD;
        end
      end
      S_PHYS: begin
        paddr_pg_nxt  = au_result;
        next_free_nxt = next_free_r + CW'(1);
        state_nxt     = S_CREAD;
      end
      S_CREAD: begin
        state_nxt = S_CWRITE;
      end
      S_CWRITE: begin
        if (!present) begin
          cur_nxt       = PW'(next_free_r);
          next_free_nxt = next_free_r + CW'(1);
        end else begin
          cur_nxt = au_result[PW-1:0];
        end
        if (lvl_r == 2'd2) begin
          state_nxt = S_LEAF;
        end else begin
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = S_CREAD;
        end
      end
      S_LEAF: begin
        res_value_nxt = leaf_value;
        res_mphys_nxt = {paddr_pg_r, 12'b0};
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_mphys_nxt  = res_mphys_r;
          out_used_nxt   = USED_W'(next_free_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= CW'(1);
      pool_base_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      pool_base_r <= pool_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    cur_r        <= cur_nxt;
    missing_r    <= missing_nxt;
    foreign_r    <= foreign_nxt;
    alloc_r      <= alloc_nxt;
    virt_pg_r    <= virt_pg_nxt;
    phys_pg_r    <= phys_pg_nxt;
    fx_r         <= fx_nxt;
    rent_r       <= rent_nxt;
    paddr_pg_r   <= paddr_pg_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_mphys_r  <= res_mphys_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_mphys_r  <= out_mphys_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.entry_value = out_value_r;
  assign out_if.mapped_phys = out_mphys_r;
  assign out_if.pages_used  = out_used_r;

  `FPTM_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, !in_if.ready,
    "input still ready in the cycle after a transfer")
  `FPTM_ASSERT_SAME(a_wr_states, clk, rst_n, wr_en,
    (state_r == S_CLEAR) || (state_r == S_CWRITE) || (state_r == S_LEAF),
    "table store written outside clear, link or leaf state")
  `FPTM_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid_r),
    $past(state_r == S_FINISH), "result raised without a finished item")

endmodule
